>>> rtl/core/radix64_text_encoder_defines.svh
// Assertion macros shared by the radix-64 text encoder RTL.
`ifndef RADIX64_TEXT_ENCODER_DEFINES_SVH
`define RADIX64_TEXT_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define R64E_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define R64E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/r64e_pkg.sv
// Package: types, constants and the character map of the radix-64 text encoder.
`default_nettype none

package r64e_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] CharNewline = 7'd10;
  localparam logic [6:0] CharPad     = 7'd42;

  // leftover bit counts carried between bytes
  localparam logic [2:0] LeftZero = 3'd0;
  localparam logic [2:0] LeftTwo  = 3'd2;
  localparam logic [2:0] LeftFour = 3'd4;

  // one classified byte: up to three 6-bit groups, pad count and end marker
  typedef struct packed {
    logic [1:0]      n_alpha;
    logic [2:0][5:0] alpha;
    logic [1:0]      n_pad;
    logic            last;
  } job_t;

  // "./" then digits, upper case, lower case
  function automatic logic [6:0] radix_char(input logic [5:0] v);
    logic [6:0] ext;
    ext = {1'b0, v};
    if (v < 6'd12) begin
      radix_char = ext + 7'd46;
    end else if (v < 6'd38) begin
      radix_char = ext + 7'd53;
    end else begin
      radix_char = ext + 7'd59;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/r64e_front.sv
// Front end: accept bytes, split them into 6-bit groups and flush on the final byte.
`default_nettype none

module r64e_front
  import r64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  input  wire logic       q_full,
  output      logic       push,
  output      job_t       push_job
);

  logic [3:0] leftover_bits;
  logic [2:0] leftover_count;
  logic [3:0] rem_bits;
  logic [2:0] rem_count;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_job       = '0;
    push_job.last  = final_byte;
    rem_bits       = '0;
    rem_count      = LeftZero;
    case (leftover_count)
      LeftZero: begin
        push_job.alpha[0] = data_byte[7:2];
        push_job.n_alpha  = 2'd1;
        rem_bits          = {2'b00, data_byte[1:0]};
        rem_count         = LeftTwo;
        if (final_byte) begin
          push_job.alpha[1] = {data_byte[1:0], 4'b0000};
          push_job.n_alpha  = 2'd2;
          push_job.n_pad    = 2'd2;
        end
      end
      LeftTwo: begin
        push_job.alpha[0] = {leftover_bits[1:0], data_byte[7:4]};
        push_job.n_alpha  = 2'd1;
        rem_bits          = data_byte[3:0];
        rem_count         = LeftFour;
        if (final_byte) begin
          push_job.alpha[1] = {data_byte[3:0], 2'b00};
          push_job.n_alpha  = 2'd2;
          push_job.n_pad    = 2'd1;
        end
      end
      default: begin
        push_job.alpha[0] = {leftover_bits, data_byte[7:6]};
        push_job.alpha[1] = data_byte[5:0];
        push_job.n_alpha  = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= LeftZero;
    end else if (push) begin
      if (final_byte) begin
        leftover_bits  <= '0;
        leftover_count <= LeftZero;
      end else begin
        leftover_bits  <= rem_bits;
        leftover_count <= rem_count;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/r64e_queue.sv
// Short job queue between the front end and the character sequencer.
`default_nettype none

module r64e_queue
  import r64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output      job_t pop_job,
  output      logic full,
  output      logic nonempty
);
  `include "radix64_text_encoder_defines.svh"

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign nonempty = (count != '0);
  assign pop_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `R64E_ASSERT_NOW(a_q_bound, clk, rst, 1'b1, count <= QCntW'(QDepth), "queue count overflow")
  `R64E_ASSERT_NOW(a_q_pop_empty, clk, rst, pop, count != '0, "pop from empty queue")
  `R64E_ASSERT_NEXT(a_q_grow, clk, rst, push && !pop, count == $past(count) + 1'b1, "count did not grow")
endmodule

`default_nettype wire

>>> rtl/core/r64e_back.sv
// Back end: emit characters, newlines and pads one per cycle into the output register while the output can advance.
`default_nettype none

module r64e_back
  import r64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] line_length,
  input  wire logic       q_nonempty,
  input  wire job_t       q_job,
  output      logic       pop,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [6:0] out_char,
  output      logic       end_of_text
);
  `include "radix64_text_encoder_defines.svh"

  job_t       job;
  logic       busy;
  logic [1:0] alpha_idx;
  logic       nl_pending;
  logic [1:0] pad_left;
  logic [7:0] line_pos;

  logic [1:0] alpha_idx_next;
  logic       nl_pending_next;
  logic [1:0] pad_left_next;
  logic [7:0] line_pos_next;
  logic [7:0] pos_inc;
  logic [5:0] cur_alpha;
  logic [6:0] char_next;
  logic       end_next;
  logic       adv;
  logic       emit;
  logic       done;

  assign adv  = !out_valid || out_ready;
  assign emit = busy && adv;
  assign pop  = q_nonempty && (!busy || (emit && done));

  always_comb begin
    alpha_idx_next  = alpha_idx;
    nl_pending_next = nl_pending;
    pad_left_next   = pad_left;
    line_pos_next   = line_pos;
    pos_inc         = line_pos + 8'd1;
    char_next       = CharPad;
    case (alpha_idx)
      2'd0:    cur_alpha = job.alpha[0];
      2'd1:    cur_alpha = job.alpha[1];
      default: cur_alpha = job.alpha[2];
    endcase
    if (nl_pending) begin
      char_next       = CharNewline;
      nl_pending_next = 1'b0;
    end else if (alpha_idx != job.n_alpha) begin
      char_next      = radix_char(cur_alpha);
      alpha_idx_next = alpha_idx + 2'd1;
      if (line_length != 8'd0) begin
        if (pos_inc >= line_length) begin
          nl_pending_next = 1'b1;
          line_pos_next   = '0;
        end else begin
          line_pos_next = pos_inc;
        end
      end
    end else begin
      pad_left_next = pad_left - 2'd1;
    end
    done     = !nl_pending_next && (alpha_idx_next == job.n_alpha) && (pad_left_next == 2'd0);
    end_next = done && job.last;
    // a message end restarts the line count
    if (end_next) begin
      line_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
    if (emit) begin
      out_char    <= char_next;
      end_of_text <= end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      alpha_idx  <= '0;
      nl_pending <= 1'b0;
      pad_left   <= '0;
      line_pos   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (emit) begin
        line_pos <= line_pos_next;
      end
      if (pop) begin
        busy       <= 1'b1;
        alpha_idx  <= '0;
        nl_pending <= 1'b0;
        pad_left   <= q_job.n_pad;
      end else if (emit) begin
        alpha_idx  <= alpha_idx_next;
        nl_pending <= nl_pending_next;
        pad_left   <= pad_left_next;
        if (done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `R64E_ASSERT_NOW(a_b_idx, clk, rst, busy && !nl_pending, alpha_idx <= job.n_alpha, "group index past job")
  `R64E_ASSERT_NOW(a_b_pad, clk, rst, busy, pad_left <= 2'd2, "pad count out of range")
  `R64E_ASSERT_NEXT(a_b_eol, clk, rst, emit && end_next, line_pos == '0, "line count not cleared")
endmodule

`default_nettype wire

>>> rtl/core/radix64_text_encoder.sv
// Top level of the radix-64 text encoder: config register, front end, queue, back end.
// A byte passes through the job queue and the back-end job register to the output register.
// Throughput: one character per cycle from the single output register of the back end while
// m_tready allows; a byte gives 1 to 6 characters, about 1.33 plus newlines on average.
// The front end keeps taking bytes while the four-entry job queue has room.
// Reset (rst, synchronous, active high) clears line_length, leftover bits, line count,
// queue and output valid.
`default_nettype none

module radix64_text_encoder
  import r64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration: line_length, written when cfg_wen is high
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  // input stream
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // final_byte
  // output stream
  output      logic       m_tvalid,
  input  wire logic       m_tready,
  output      logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output      logic       m_tlast    // end_of_text
);

  logic [7:0] line_length;
  logic       q_push;
  job_t       q_push_job;
  logic       q_pop;
  job_t       q_pop_job;
  logic       q_full;
  logic       q_nonempty;
  logic [6:0] out_char;

  // Hold the characters-per-line setting; zero turns line breaks off.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else if (cfg_wen) begin
      line_length <= cfg_wdata;
    end
  end

  // Front end: classify each transferred byte into a job of 6-bit groups and pads.
  r64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .q_full     (q_full),
    .push       (q_push),
    .push_job   (q_push_job)
  );

  // Decouple the two sides so a stalled output does not stall input at once.
  r64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // Back end: walk each job, insert newlines at line ends, append pads.
  r64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .q_nonempty  (q_nonempty),
    .q_job       (q_pop_job),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_char    (out_char),
    .end_of_text (m_tlast)
  );

  // Pad the 7-bit character up to a whole byte.
  assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

>>> tb/radix64_text_checker.sv
// Checker for the radix-64 text encoder: predicts the character stream and compares it.
module radix64_text_checker
  import r64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  input  logic       m_tlast,   // end_of_text
  output int         mismatches,
  output int         pending,
  output int         chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] code;
    logic       eot;
  } text_char_t;

  text_char_t expected_text[$];

  logic [7:0] line_len;
  logic [7:0] line_pos;
  logic [3:0] carry_bits;
  logic [2:0] carry_cnt;
  int         errs = 0;
  int         nchars = 0;

  // alphabet: '.', '/', digits, upper case, lower case
  function automatic logic [6:0] glyph_of(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd2) return 7'd46 + w;
    if (v < 6'd12) return 7'd48 + (w - 7'd2);
    if (v < 6'd38) return 7'd65 + (w - 7'd12);
    return 7'd97 + (w - 7'd38);
  endfunction

  function automatic void push_char(input logic [6:0] code);
    expected_text.push_back(text_char_t'{code: code, eot: 1'b0});
  endfunction

  // one alphabet character, then a newline once the line is full
  function automatic void emit_alpha(input logic [5:0] v);
    push_char(glyph_of(v));
    if (line_len != 8'd0) begin
      line_pos = line_pos + 8'd1;
      if (line_pos >= line_len) begin
        push_char(CharNewline);
        line_pos = 8'd0;
      end
    end
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [11:0] acc;
    int          nbits;
    int          first;
    first = expected_text.size();
    nbits = int'(carry_cnt) + 8;
    acc   = {carry_bits, b} & ((12'd1 << nbits) - 12'd1);
    while (nbits >= 6) begin
      nbits -= 6;
      emit_alpha(6'((acc >> nbits) & 12'h03f));
    end
    acc = acc & ((12'd1 << nbits) - 12'd1);
    if (!fin) begin
      carry_bits = acc[3:0];
      carry_cnt  = 3'(nbits);
      return;
    end
    if (nbits > 0) emit_alpha(6'(acc << (6 - nbits)));
    if (nbits == 2) begin
      push_char(CharPad);
      push_char(CharPad);
    end else if (nbits == 4) begin
      push_char(CharPad);
    end
    if (expected_text.size() > first) expected_text[expected_text.size() - 1].eot = 1'b1;
    carry_bits = 4'd0;
    carry_cnt  = 3'd0;
    line_pos   = 8'd0;
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      expected_text.delete();
      line_len   = 8'd0;
      line_pos   = 8'd0;
      carry_bits = 4'd0;
      carry_cnt  = 3'd0;
    end else begin
      if (m_tvalid && m_tready) begin
        nchars++;
        if (expected_text.size() == 0) begin
          $error("unexpected character: out_char actual %0d end_of_text actual %0b",
                 m_tdata[6:0], m_tlast);
          errs++;
        end else begin
          want = expected_text.pop_front();
          if (m_tdata[6:0] !== want.code) begin
            $error("out_char mismatch: expected %0d actual %0d", want.code, m_tdata[6:0]);
            errs++;
          end
          if (m_tlast !== want.eot) begin
            $error("end_of_text mismatch: expected %0b actual %0b", want.eot, m_tlast);
            errs++;
          end
          if (m_tdata[7] !== 1'b0) begin
            $error("m_tdata[7] mismatch: expected 0 actual %0b", m_tdata[7]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) encode_byte(s_tdata, s_tlast);
      if (cfg_wen) line_len = cfg_wdata;
    end
    mismatches    <= errs;
    pending       <= expected_text.size();
    chars_checked <= nchars;
  end

endmodule

>>> tb/testbench.sv
// Top of the radix-64 text encoder testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Every block input starts at a known value.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_wen   = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       s_tvalid  = 1'b0;
  logic [7:0] s_tdata   = 8'd0;  // [7:0] data_byte
  logic       s_tlast   = 1'b0;  // final_byte
  logic       m_tready  = 1'b0;

  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;           // [6:0] out_char, [7] zero
  wire        m_tlast;           // end_of_text

  int mismatches;
  int pending;
  int chars_checked;

  // Stimulus-side controls, written only with nonblocking assignments.
  bit calm        = 1'b0;  // no idling on either side while set
  int squeeze_req = 0;     // each increment asks the receiver for one long hold-off

  int bytes_sent       = 0;
  int messages_sent    = 0;
  int settings_written = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radix64_text_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  radix64_text_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  // Offer one byte and hold it until the transfer. A gap, if any, comes first;
  // without a gap valid simply stays high from the previous transfer.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 19) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  // Drop valid and wait until every predicted character has come out, then
  // give the pipeline a few more cycles so the block is truly idle.
  task automatic drain_text();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write line_length; only called while the block is idle.
  task automatic write_line_length(input logic [7:0] len);
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    settings_written++;
  endtask

  // Receiver: random back-pressure, a calm stretch, and on request a long
  // hold-off while the sender keeps offering, so the job queue fills and the
  // input stalls.
  initial begin : rx_side
    int hold_left;
    int squeeze_seen;
    hold_left    = 0;
    squeeze_seen = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm || rst) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Stimulus: directed messages first, then random messages in phases, each
  // phase under its own line length.
  initial begin : tx_side
    int         rnd_bytes;
    int         len;
    int         msgs_left;
    int         phase_no;
    int         stalls;
    logic [7:0] next_len;
    rnd_bytes = 0;
    msgs_left = 0;
    phase_no  = 0;
    stalls    = 0;

    // Hold reset, then release it once for the whole run.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Line breaks off (reset value).
    // One byte: a zero-padded partial group and two pads.
    send_byte(8'h00, 1'b1);
    // Two bytes of all ones: one pad.
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    // Three bytes: the groups close exactly, no pad.
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b1);
    drain_text();

    // A newline after every character; the trailing newline ends the text.
    write_line_length(8'd1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'hc3, 1'b1);
    // One byte on one-character lines: the most results a byte can give.
    send_byte(8'h3c, 1'b1);
    drain_text();

    // Longest lines, then lower the length below the count in mid-message:
    // the next character is followed by a newline at once.
    write_line_length(8'd255);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    drain_text();
    write_line_length(8'd3);
    send_byte(8'h9a, 1'b0);
    send_byte(8'hbc, 1'b1);
    drain_text();

    // Random messages, mostly short, a few long.
    while (rnd_bytes < 460) begin
      if (msgs_left == 0) begin
        drain_text();
        case ($urandom_range(0, 5))
          0:       next_len = 8'd0;
          1:       next_len = 8'd255;
          2:       next_len = 8'd1;
          3:       next_len = 8'd2;
          default: next_len = 8'($urandom_range(3, 80));
        endcase
        if (phase_no == 0) next_len = 8'd0;
        write_line_length(next_len);
        phase_no++;
        msgs_left = $urandom_range(4, 8);
      end
      // Calm stretch in the middle of the random part.
      calm <= (rnd_bytes >= 200 && rnd_bytes < 300);
      // Two long receiver hold-offs.
      if ((stalls == 0 && rnd_bytes >= 60) || (stalls == 1 && rnd_bytes >= 330)) begin
        squeeze_req <= squeeze_req + 1;
        stalls++;
      end
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 9) : $urandom_range(10, 40);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == len - 1);
        rnd_bytes++;
      end
      msgs_left--;
    end

    calm <= 1'b0;
    drain_text();

    $display("Run covered %0d bytes in %0d messages over %0d line-length settings.",
             bytes_sent, messages_sent, settings_written);
    $display("Compared %0d characters, with two long receiver hold-offs.", chars_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Timeout: characters still outstanding: %0d", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
